// ===== design/nsr_pkg.sv =====
// Shared widths, register map, reset values and config struct for the Newton square root block.
package nsr_pkg;

  localparam int unsigned ROOT_W         = 32;
  localparam int unsigned HALF_W         = ROOT_W / 2;
  localparam int unsigned TOL_W          = 16;
  localparam int unsigned PASS_W         = 7;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned MAX_PASSES_DEF = 32;

  localparam logic [ROOT_W-1:0] GUESS_RST = ROOT_W'(65536);
  localparam logic [TOL_W-1:0]  TOL_RST   = TOL_W'(328);

  // Register select bit (paddr[2])
  localparam logic REG_GUESS = 1'b0;
  localparam logic REG_TOL   = 1'b1;

  typedef struct packed {
    logic [ROOT_W-1:0] guess;
    logic [TOL_W-1:0]  tol;
  } cfg_t;

endpackage

// ===== design/nsr_regs.sv =====
// APB configuration registers: starting guess and convergence tolerance.
module nsr_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output nsr_pkg::cfg_t                      cfg_o
);

  nsr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic          sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        nsr_pkg::REG_GUESS: cfg_d.guess = pwdata[nsr_pkg::ROOT_W-1:0];
        nsr_pkg::REG_TOL:   cfg_d.tol   = pwdata[nsr_pkg::TOL_W-1:0];
        default:            cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guess <= nsr_pkg::GUESS_RST;
      cfg_q.tol   <= nsr_pkg::TOL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (sel)
      nsr_pkg::REG_GUESS: prdata = nsr_pkg::APB_DATA_W'(cfg_q.guess);
      nsr_pkg::REG_TOL:   prdata = nsr_pkg::APB_DATA_W'(cfg_q.tol);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/nsr_div.sv =====
// Bit-serial restoring divider: floor((radicand << 16) / guess), saturated to 32 bits.
module nsr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nsr_pkg::ROOT_W-1:0]    radicand_i,
  input  logic [nsr_pkg::ROOT_W-1:0]    guess_i,
  output logic                          done_o,
  output logic [nsr_pkg::ROOT_W-1:0]    quot_o
);

  localparam int unsigned W     = nsr_pkg::ROOT_W;
  localparam int unsigned HW    = nsr_pkg::HALF_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dvd_q, dvd_d;
  logic [W-1:0]     quot_q, quot_d;
  logic             ovf;
  logic [W:0]       trial;
  logic [W+1:0]     sub;

  // Quotient needs more than 32 bits when the radicand's integer part reaches the guess.
  assign ovf   = (guess_i[W-1:HW] == '0) && (radicand_i[W-1:HW] >= guess_i[HW-1:0]);
  assign trial = {rem_q, dvd_q[W-1]};
  assign sub   = {1'b0, trial} - {2'b00, guess_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    if (!busy_q) begin
      if (start_i) begin
        if (ovf) begin
          quot_d = '1;
          done_d = 1'b1;
        end else begin
          // Top 16 quotient bits are zero; partial remainder is the integer part.
          rem_d  = W'(radicand_i[W-1:HW]);
          dvd_d  = {radicand_i[HW-1:0], {HW{1'b0}}};
          quot_d = '0;
          cnt_d  = '0;
          busy_d = 1'b1;
        end
      end
    end else begin
      if (!sub[W+1]) begin
        rem_d  = sub[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/newton_square_root.sv =====
// Newton square root top level: APB registers, pass sequencer and bit-serial divider.
// Each Newton pass runs start, bit-serial divide, add and check steps; a pass whose
// quotient saturates skips the bit-serial shifting. An item takes up to MAX_PASSES
// passes; one item is in work at a time.
// A new item is taken while the previous result still waits on the output.
// rst_ni clears control state and loads guess 1.0 and tolerance 328; no clearing pass.
module newton_square_root #(
  parameter int unsigned MAX_PASSES = nsr_pkg::MAX_PASSES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] radicand
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // [31:0] root, [38:32] passes
  output logic                           m_axis_tuser   // [0] converged
);

  localparam int unsigned W  = nsr_pkg::ROOT_W;
  localparam int unsigned PW = nsr_pkg::PASS_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  nsr_pkg::cfg_t cfg;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] pass_q, pass_d;
  logic          mvalid_q, mvalid_d;
  logic [W-1:0]  rad_q, rad_d;
  logic [W-1:0]  guess_q, guess_d;
  logic [W-1:0]  next_q, next_d;
  logic [W-1:0]  res_root_q, res_root_d;
  logic          res_conv_q, res_conv_d;
  logic [W-1:0]  mroot_q, mroot_d;
  logic          mconv_q, mconv_d;
  logic [PW-1:0] mpass_q, mpass_d;

  logic          in_acc;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  quot;
  logic [W:0]    sum;
  logic [W:0]    dnext;
  logic [W-1:0]  diff;
  logic          conv;

  nsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .radicand_i (rad_q),
    .guess_i    (guess_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign sum   = {1'b0, guess_q} + {1'b0, quot};
  assign dnext = {1'b0, next_q} - {1'b0, guess_q};
  assign diff  = dnext[W] ? (guess_q - next_q) : dnext[W-1:0];
  assign conv  = diff < W'(cfg.tol);

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    mvalid_d   = mvalid_q & ~m_axis_tready;
    rad_d      = rad_q;
    guess_d    = guess_q;
    next_d     = next_q;
    res_root_d = res_root_q;
    res_conv_d = res_conv_q;
    mroot_d    = mroot_q;
    mconv_d    = mconv_q;
    mpass_d    = mpass_q;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rad_d   = s_axis_tdata;
          guess_d = cfg.guess;
          pass_d  = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (guess_q == '0) begin
          res_root_d = '0;
          res_conv_d = 1'b0;
          state_d    = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        next_d  = sum[W:1];
        pass_d  = pass_q + 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (conv) begin
          res_root_d = next_q;
          res_conv_d = 1'b1;
          state_d    = ST_FIN;
        end else if (pass_q == PW'(MAX_PASSES)) begin
          res_root_d = next_q;
          res_conv_d = 1'b0;
          state_d    = ST_FIN;
        end else begin
          guess_d = next_q;
          state_d = ST_START;
        end
      end
      ST_FIN: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mroot_d  = res_root_q;
          mconv_d  = res_conv_q;
          mpass_d  = pass_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pass_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pass_q   <= pass_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q      <= rad_d;
    guess_q    <= guess_d;
    next_q     <= next_d;
    res_root_q <= res_root_d;
    res_conv_q <= res_conv_d;
    mroot_q    <= mroot_d;
    mconv_q    <= mconv_d;
    mpass_q    <= mpass_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {1'b0, mpass_q, mroot_q};
  assign m_axis_tuser  = mconv_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_chk_has_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> pass_q != '0)
    else $error("check step with no pass counted");

  a_pass_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> pass_q <= PW'(MAX_PASSES))
    else $error("pass count beyond limit");

  a_conv_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[38:32] != '0)
    else $error("converged result with zero passes");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Newton square root block: APB setup, stream traffic, scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PASS_LIMIT = nsr_pkg::MAX_PASSES_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 1200;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [nsr_pkg::ROOT_W-1:0] root;
    logic                       converged;
    logic [nsr_pkg::PASS_W-1:0] passes;
  } root_result_t;

  class root_scoreboard;
    logic [nsr_pkg::ROOT_W-1:0] start_guess;
    logic [nsr_pkg::TOL_W-1:0]  tol;
    int unsigned                pass_limit;
    root_result_t               pending_roots[$];
    int unsigned                mismatches;

    function new(int unsigned limit);
      start_guess = nsr_pkg::GUESS_RST;
      tol         = nsr_pkg::TOL_RST;
      pass_limit  = limit;
      mismatches  = 0;
    endfunction

    function root_result_t newton_root(logic [nsr_pkg::ROOT_W-1:0] rad);
      root_result_t               r;
      logic [nsr_pkg::ROOT_W-1:0] guess;
      logic [nsr_pkg::ROOT_W-1:0] new_guess;
      logic [nsr_pkg::ROOT_W-1:0] diff;
      logic [63:0]                quot;
      logic [nsr_pkg::ROOT_W:0]   total;
      int unsigned                done;
      guess       = start_guess;
      new_guess   = '0;
      done        = 0;
      r.converged = 1'b0;
      while (done < pass_limit) begin
        // a zero guess ends the run without dividing
        if (guess == '0) begin
          new_guess = '0;
          break;
        end
        quot = {16'b0, rad, 16'b0} / {32'b0, guess};
        if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
        total     = {1'b0, guess} + {1'b0, quot[31:0]};
        new_guess = total[nsr_pkg::ROOT_W:1];
        done      = done + 1;
        diff      = (new_guess >= guess) ? new_guess - guess : guess - new_guess;
        if (diff < {16'b0, tol}) begin
          r.converged = 1'b1;
          break;
        end
        guess = new_guess;
      end
      r.root   = new_guess;
      r.passes = done[nsr_pkg::PASS_W-1:0];
      return r;
    endfunction

    function void note_radicand(logic [nsr_pkg::ROOT_W-1:0] rad);
      pending_roots.push_back(newton_root(rad));
    endfunction

    function void check_result(logic [nsr_pkg::ROOT_W-1:0] root, logic conv,
                               logic [nsr_pkg::PASS_W-1:0] passes);
      root_result_t exp_r;
      if (pending_roots.size() == 0) begin
        $error("unexpected result: root %h converged %0d passes %0d", root, conv, passes);
        mismatches++;
        return;
      end
      exp_r = pending_roots.pop_front();
      if (root !== exp_r.root) begin
        $error("root: expected %h, got %h", exp_r.root, root);
        mismatches++;
      end
      if (conv !== exp_r.converged) begin
        $error("converged: expected %0d, got %0d", exp_r.converged, conv);
        mismatches++;
      end
      if (passes !== exp_r.passes) begin
        $error("passes: expected %0d, got %0d", exp_r.passes, passes);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [nsr_pkg::APB_ADDR_W-1:0] paddr;
  logic [nsr_pkg::APB_DATA_W-1:0] pwdata;
  logic [nsr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata;   // [31:0] radicand
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [39:0]                    m_axis_tdata;   // [31:0] root, [38:32] passes
  logic                           m_axis_tuser;   // [0] converged

  root_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  int unsigned    quiet_cycles;

  newton_square_root #(
    .MAX_PASSES(PASS_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]);
    end
  end

  // watchdog: cycles with no beat on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SEND) ? 57 : (mode == IDLE_BOTH) ? 30 : 0;
    stall_pct     = (mode == IDLE_RECV) ? 57 : (mode == IDLE_BOTH) ? 30 : 0;
  endtask

  task automatic apb_read(input logic sel, output logic [nsr_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_check(input logic sel);
    logic [nsr_pkg::APB_DATA_W-1:0] got;
    logic [nsr_pkg::APB_DATA_W-1:0] want;
    want = (sel == nsr_pkg::REG_GUESS) ? sb.start_guess : {16'b0, sb.tol};
    apb_read(sel, got);
    if (got !== want) begin
      $error("prdata: expected %h, got %h", want, got);
      sb.mismatches++;
    end
  endtask

  task automatic write_reg(input logic sel, input logic [nsr_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == nsr_pkg::REG_GUESS) sb.start_guess = data;
    else sb.tol = data[nsr_pkg::TOL_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_check(sel);
  endtask

  task automatic send_radicand(input logic [31:0] rad);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rad;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_radicand(rad);
  endtask

  // hold the sender off until every pending root is out
  task automatic drain_roots();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_roots.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_radicand();
    logic [31:0] k;
    logic [63:0] sq;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 60) return $urandom >> $urandom_range(31);
    if (pick < 75) begin
      // near-perfect squares in Q16.16
      k  = $urandom_range(32'h00FF_FFFF);
      sq = {32'b0, k} * {32'b0, k};
      return sq[47:16] + $urandom_range(2);
    end
    if (pick < 85) return $urandom_range(3);
    if (pick < 92) return 32'hFFFF_FFFF - $urandom_range(3);
    return 32'h1 << $urandom_range(31);
  endfunction

  task automatic run_phase(input logic [31:0] guess, input logic [15:0] tol,
                           input idle_mode_e mode, input int unsigned count);
    drain_roots();
    write_reg(nsr_pkg::REG_GUESS, guess);
    // upper bits are don't-care for the tolerance register
    write_reg(nsr_pkg::REG_TOL, {16'($urandom), tol});
    set_idle(mode);
    send_radicand(32'h0000_0000);
    send_radicand(32'hFFFF_FFFF);
    repeat (count) send_radicand(random_radicand());
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    sb            = new(PASS_LIMIT);
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values, then field extremes at the default setting
    read_check(nsr_pkg::REG_GUESS);
    read_check(nsr_pkg::REG_TOL);
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0000_8000);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0004_0000);
    send_radicand(32'h5555_5555);
    send_radicand(32'hAAAA_AAAA);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h8000_0000);
    send_radicand(32'hFFFF_FFFF);

    run_phase(32'h0001_0000, 16'd328,   IDLE_NONE, 240);
    run_phase(32'h0000_0001, 16'hFFFF,  IDLE_SEND, 100);  // quotient saturates
    run_phase(32'hFFFF_FFFF, 16'd1,     IDLE_RECV, 150);
    run_phase(32'h0000_0000, 16'd100,   IDLE_BOTH, 20);   // zero guess
    run_phase(32'h0000_0001, 16'd0,     IDLE_BOTH, 60);   // never converges
    run_phase(32'h0010_0000, 16'd16,    IDLE_SEND, 200);
    run_phase($urandom,      16'($urandom), IDLE_RECV, 200);
    run_phase(32'h8000_0000, 16'd4,     IDLE_NONE, 160);

    drain_roots();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
